FILE: rtl/ccfd_pkg.sv
// Shared types, codes, reset values and CRC fold functions for the frame deframer.
package ccfd_pkg;

	localparam int MAX_FRAME_SIZE_DEF = 256;
	localparam int FIXED_OVERHEAD = 9;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HCRC_POLY = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HCRC_SEED = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FCRC_POLY = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FCRC_SEED = 3'd4;

	localparam logic [7:0] START_BYTE_RST = 8'hA5;
	localparam logic [7:0] HCRC_POLY_RST = 8'h8C;
	localparam logic [7:0] HCRC_SEED_RST = 8'hFF;
	localparam logic [15:0] FCRC_POLY_RST = 16'h8408;
	localparam logic [15:0] FCRC_SEED_RST = 16'hFFFF;

	localparam logic [2:0] KIND_PAYLOAD = 3'd0;
	localparam logic [2:0] KIND_GOOD = 3'd1;
	localparam logic [2:0] KIND_CRC16_ERR = 3'd2;
	localparam logic [2:0] KIND_CRC8_ERR = 3'd3;
	localparam logic [2:0] KIND_TOO_LONG = 3'd4;

	typedef struct packed {
		logic [7:0] start_byte;
		logic [7:0] hcrc_poly;
		logic [7:0] hcrc_seed;
		logic [15:0] fcrc_poly;
		logic [15:0] fcrc_seed;
	} cfg_t;

	typedef struct packed {
		logic emit;
		logic [2:0] kind;
		logic [7:0] payload_byte;
		logic [7:0] payload_offset;
		logic [15:0] command_id;
		logic [7:0] payload_length;
		logic [7:0] sequence_number;
	} result_t;

	// Reflected CRC8, one byte folded in bit by bit.
	function automatic logic [7:0] fold8(input logic [7:0] crc, input logic [7:0] b,
			input logic [7:0] poly);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
		end
		return c;
	endfunction

	// Reflected CRC16, low byte folded in, high byte shifted down.
	function automatic logic [15:0] fold16(input logic [15:0] crc, input logic [7:0] b,
			input logic [15:0] poly);
		logic [15:0] c;
		c = {8'h00, crc[7:0] ^ b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
		end
		return {8'h00, crc[15:8]} ^ c;
	endfunction

endpackage

FILE: rtl/crc_checked_frame_deframer.sv
// Top level of the byte-stream frame deframer with header CRC8 and frame CRC16 checks.
// Usage:
//   Input channel: in_valid / in_stall carry one received byte (rx_byte) per item.
//   Output channel: out_valid / out_stall carry at most one result per input byte:
//   a payload byte with its offset, or a verdict: good or CRC16 error with command id,
//   payload length and sequence number, header CRC8 error with sequence, or too long.
//   Configuration: cfg_wen / cfg_index / cfg_data write start byte, CRC polynomials
//   and seeds; write only while no byte is in flight.
// Throughput: one byte per cycle while out_stall does not hold a waiting result. Each
//   byte passes the input register, then the combinational parse step and the result
//   register, before its result is presented on the output. Bytes that produce no
//   result simply retire from the input register.
// Stall: when out_stall holds a waiting result, the staged byte holds in the input
//   register and in_stall rises once that register is full; one byte is still taken
//   while the result register waits.
// Reset (arst_n low): all but the byte and result data registers return to defaults,
//   the parser hunts for the start byte, and no items are pending on either channel.
module crc_checked_frame_deframer #(
	parameter int MAX_FRAME_SIZE = ccfd_pkg::MAX_FRAME_SIZE_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [7:0]                      rx_byte,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [2:0]                      kind,
	output logic [7:0]                      payload_byte,
	output logic [7:0]                      payload_offset,
	output logic [15:0]                     command_id,
	output logic [7:0]                      payload_length,
	output logic [7:0]                      sequence_number,
	input  logic                            cfg_wen,
	input  logic [ccfd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ccfd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ccfd_pkg::*;

	cfg_t cfg;
	result_t res;
	result_t out_q;
	logic out_vld_q;
	logic vld_s1;
	logic [7:0] byte_s1;
	logic advance;

	assign advance = !out_vld_q || !out_stall;
	assign in_stall = vld_s1 && !advance;

	ccfd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ccfd_parser #(
		.MAX_FRAME_SIZE (MAX_FRAME_SIZE)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.byte_vld (vld_s1),
		.rx_byte  (byte_s1),
		.advance  (advance),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!in_stall) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (advance) begin
			out_vld_q <= vld_s1 && res.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && vld_s1 && res.emit) begin
			out_q <= res;
		end
	end

	assign out_valid = out_vld_q;
	assign kind = out_q.kind;
	assign payload_byte = out_q.payload_byte;
	assign payload_offset = out_q.payload_offset;
	assign command_id = out_q.command_id;
	assign payload_length = out_q.payload_length;
	assign sequence_number = out_q.sequence_number;

endmodule

FILE: rtl/ccfd_cfg_regs.sv
// Configuration registers: start byte, CRC polynomials and seeds.
module ccfd_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wen,
	input  logic [ccfd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ccfd_pkg::CFG_DATA_W-1:0] cfg_data,
	output ccfd_pkg::cfg_t                 cfg
);
	import ccfd_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_byte <= START_BYTE_RST;
			cfg_q.hcrc_poly <= HCRC_POLY_RST;
			cfg_q.hcrc_seed <= HCRC_SEED_RST;
			cfg_q.fcrc_poly <= FCRC_POLY_RST;
			cfg_q.fcrc_seed <= FCRC_SEED_RST;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				CFG_START_BYTE: cfg_q.start_byte <= cfg_data[7:0];
				CFG_HCRC_POLY:  cfg_q.hcrc_poly <= cfg_data[7:0];
				CFG_HCRC_SEED:  cfg_q.hcrc_seed <= cfg_data[7:0];
				CFG_FCRC_POLY:  cfg_q.fcrc_poly <= cfg_data;
				CFG_FCRC_SEED:  cfg_q.fcrc_seed <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/ccfd_parser.sv
// Frame parse state and the per-byte step: header checks, payload pass-through, verdict.
module ccfd_parser #(
	parameter int MAX_FRAME_SIZE = ccfd_pkg::MAX_FRAME_SIZE_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ccfd_pkg::cfg_t      cfg,
	input  logic                byte_vld,
	input  logic [7:0]          rx_byte,
	input  logic                advance,
	output ccfd_pkg::result_t   res
);
	import ccfd_pkg::*;

	localparam int POS_W = $clog2(MAX_FRAME_SIZE);
	localparam int LEN_LIMIT = MAX_FRAME_SIZE - FIXED_OVERHEAD;

	localparam logic [2:0] ST_HUNT = 3'd0;
	localparam logic [2:0] ST_LEN_LO = 3'd1;
	localparam logic [2:0] ST_LEN_HI = 3'd2;
	localparam logic [2:0] ST_SEQ = 3'd3;
	localparam logic [2:0] ST_HCRC = 3'd4;
	localparam logic [2:0] ST_CMD_LO = 3'd5;
	localparam logic [2:0] ST_CMD_HI = 3'd6;
	localparam logic [2:0] ST_BODY = 3'd7;

	logic [2:0] step_q, step_d;
	logic [POS_W-1:0] pos_q, pos_d;
	logic [7:0] len_lo_q, len_lo_d;
	logic [POS_W-1:0] len_q, len_d;
	logic [7:0] seq_q, seq_d;
	logic [15:0] cmd_q, cmd_d;
	logic [7:0] hcrc_q, hcrc_d;
	logic [15:0] fcrc_q, fcrc_d;
	logic low_ok_q, low_ok_d;
	logic [15:0] len_full;
	logic [7:0] fold8_out;
	logic [15:0] fold16_out;

	assign len_full = {rx_byte, len_lo_q};
	assign fold8_out = fold8(hcrc_q, rx_byte, cfg.hcrc_poly);
	assign fold16_out = fold16(fcrc_q, rx_byte, cfg.fcrc_poly);

	always_comb begin
		step_d = step_q;
		pos_d = pos_q;
		len_lo_d = len_lo_q;
		len_d = len_q;
		seq_d = seq_q;
		cmd_d = cmd_q;
		hcrc_d = hcrc_q;
		fcrc_d = fcrc_q;
		low_ok_d = low_ok_q;
		res = '0;
		unique case (step_q)
			ST_HUNT: begin
				if (rx_byte == cfg.start_byte) begin
					hcrc_d = fold8(cfg.hcrc_seed, rx_byte, cfg.hcrc_poly);
					fcrc_d = fold16(cfg.fcrc_seed, rx_byte, cfg.fcrc_poly);
					len_lo_d = '0;
					len_d = '0;
					seq_d = '0;
					cmd_d = '0;
					pos_d = '0;
					low_ok_d = 1'b0;
					step_d = ST_LEN_LO;
				end
			end
			ST_LEN_LO: begin
				len_lo_d = rx_byte;
				hcrc_d = fold8_out;
				fcrc_d = fold16_out;
				step_d = ST_LEN_HI;
			end
			ST_LEN_HI: begin
				hcrc_d = fold8_out;
				fcrc_d = fold16_out;
				len_d = POS_W'(len_full);
				if (len_full < 16'(LEN_LIMIT)) begin
					step_d = ST_SEQ;
				end else begin
					step_d = ST_HUNT;
					res.emit = 1'b1;
					res.kind = KIND_TOO_LONG;
				end
			end
			ST_SEQ: begin
				seq_d = rx_byte;
				hcrc_d = fold8_out;
				fcrc_d = fold16_out;
				step_d = ST_HCRC;
			end
			ST_HCRC: begin
				if (rx_byte != hcrc_q) begin
					step_d = ST_HUNT;
					res.emit = 1'b1;
					res.kind = KIND_CRC8_ERR;
					res.sequence_number = seq_q;
				end else begin
					fcrc_d = fold16_out;
					step_d = ST_CMD_LO;
				end
			end
			ST_CMD_LO: begin
				cmd_d = {8'h00, rx_byte};
				fcrc_d = fold16_out;
				step_d = ST_CMD_HI;
			end
			ST_CMD_HI: begin
				cmd_d = {rx_byte, cmd_q[7:0]};
				fcrc_d = fold16_out;
				pos_d = '0;
				step_d = ST_BODY;
			end
			ST_BODY: begin
				if (pos_q < len_q) begin
					fcrc_d = fold16_out;
					pos_d = pos_q + 1'b1;
					res.emit = 1'b1;
					res.kind = KIND_PAYLOAD;
					res.payload_byte = rx_byte;
					res.payload_offset = 8'(pos_q);
				end else if (pos_q == len_q) begin
					low_ok_d = (rx_byte == fcrc_q[7:0]);
					pos_d = pos_q + 1'b1;
				end else begin
					step_d = ST_HUNT;
					pos_d = '0;
					res.emit = 1'b1;
					res.kind = (low_ok_q && rx_byte == fcrc_q[15:8]) ? KIND_GOOD
						: KIND_CRC16_ERR;
					res.command_id = cmd_q;
					res.payload_length = 8'(len_q);
					res.sequence_number = seq_q;
				end
			end
			default: ;
		endcase
	end

	// Advance parse state only when the staged byte is valid and the result register can take a result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_HUNT;
			pos_q <= '0;
			len_lo_q <= '0;
			len_q <= '0;
			seq_q <= '0;
			cmd_q <= '0;
			hcrc_q <= HCRC_SEED_RST;
			fcrc_q <= FCRC_SEED_RST;
			low_ok_q <= 1'b0;
		end else if (byte_vld && advance) begin
			step_q <= step_d;
			pos_q <= pos_d;
			len_lo_q <= len_lo_d;
			len_q <= len_d;
			seq_q <= seq_d;
			cmd_q <= cmd_d;
			hcrc_q <= hcrc_d;
			fcrc_q <= fcrc_d;
			low_ok_q <= low_ok_d;
		end
	end

endmodule
